/* src/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
`default_nettype none

package dq_pkg;

    // Field widths fixed by the request and result formats
    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK_REAR  = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [WORD_W-1:0] push_value;
    } request_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [FILL_W-1:0]        fill_count;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;  // execute the request on the input port this cycle
        logic load;    // move the pending result into the output register
    } dq_cmd_t;

endpackage

`default_nettype wire

/* src/dq_ctrl.sv */
// Controller state machine for the double-ended queue.
`default_nettype none

module dq_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output dq_pkg::dq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RESULT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   load;

    // Take a request only when no result is pending inside
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Load the output register once it is empty or being drained
    assign load = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);

    assign cmd.accept = accept;
    assign cmd.load   = load;
    assign m_valid    = m_valid_reg;

    // Advance the state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the receiver takes it
    assign m_valid_next = load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/dq_datapath.sv */
// Datapath of the double-ended queue: word store, head and count, result register.
`default_nettype none

module dq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dq_pkg::dq_cmd_t   cmd,
    input  wire dq_pkg::request_t  s_data,
    output dq_pkg::result_t        m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]      DEPTH_S    = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0]    COUNT_FULL = CW'(DEPTH);
    localparam logic [AW-1:0]    LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [63:0]      EMPTY_WORD = 64'({DATA_WIDTH{1'b1}});

    // Slot that lies off positions past base, with wrap-around
    function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW + 1)'(base) + (AW + 1)'(off);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [DATA_WIDTH-1:0]     rd_data_reg;
    logic [dq_pkg::STATUS_W-1:0] p_status_reg, p_status_next;
    logic                      p_use_reg, p_use_next;
    logic [CW-1:0]             p_count_reg;
    dq_pkg::result_t           out_reg;

    logic [dq_pkg::OPCODE_W-1:0] op;
    logic                      is_push;
    logic                      is_read;
    logic                      is_front;
    logic                      full;
    logic                      empty;
    logic [AW-1:0]             head_dec;
    logic [AW-1:0]             head_inc;
    logic [AW-1:0]             rear_slot;
    logic [AW-1:0]             rear_push;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic                      wr_en;
    logic [63:0]               push_ext;
    logic [63:0]               rv_ext;

    // Decode the request
    assign op       = s_data.opcode;
    assign is_push  = (op == dq_pkg::OP_PUSH_FRONT) || (op == dq_pkg::OP_PUSH_REAR);
    assign is_read  = (op == dq_pkg::OP_POP_FRONT) || (op == dq_pkg::OP_POP_REAR)
                   || (op == dq_pkg::OP_PEEK_FRONT) || (op == dq_pkg::OP_PEEK_REAR);
    assign is_front = (op == dq_pkg::OP_POP_FRONT) || (op == dq_pkg::OP_PEEK_FRONT);
    assign full     = (count_reg == COUNT_FULL);
    assign empty    = (count_reg == '0);

    // Ring positions around head and tail
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc  = wrap_slot(head_reg, CW'(1));
    assign rear_slot = wrap_slot(head_reg, count_reg - CW'(1));
    assign rear_push = wrap_slot(head_reg, count_reg);
    assign rd_addr   = is_front ? head_reg : rear_slot;

    // Only the low DATA_WIDTH bits of a pushed word are kept
    assign push_ext = {32'b0, s_data.push_value};

    // Execute the request: pointer update, store write, status
    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        p_status_next = dq_pkg::ST_OK;
        p_use_next    = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = rear_push;
        if (cmd.accept) begin
            if (is_push) begin
                if (full) begin
                    p_status_next = dq_pkg::ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (op == dq_pkg::OP_PUSH_FRONT) begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                end
            end else if (is_read) begin
                if (empty) begin
                    p_status_next = dq_pkg::ST_EMPTY;
                end else begin
                    p_use_next = 1'b1;
                    if (op == dq_pkg::OP_POP_FRONT) begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end else if (op == dq_pkg::OP_POP_REAR) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
        end
    end

    // Write and read the word store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= push_ext[DATA_WIDTH-1:0];
        end
        if (cmd.accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold the queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Capture the pending result of the executed request
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            p_status_reg <= p_status_next;
            p_use_reg    <= p_use_next;
            p_count_reg  <= count_next;
        end
    end

    // Form the read word: stored data, all ones when empty, zero otherwise
    always_comb begin
        if (p_use_reg) begin
            rv_ext = 64'(rd_data_reg);
        end else if (p_status_reg == dq_pkg::ST_EMPTY) begin
            rv_ext = EMPTY_WORD;
        end else begin
            rv_ext = '0;
        end
    end

    // Load the output register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_reg.read_value <= rv_ext[dq_pkg::WORD_W-1:0];
            out_reg.status     <= p_status_reg;
            out_reg.fill_count <= dq_pkg::FILL_W'(p_count_reg);
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

/* src/double_ended_queue_top.sv */
// Top level of the double-ended queue: controller plus datapath.
//
// Requests enter on s_valid/s_ready/s_data: an opcode (push front, push rear,
// pop front, pop rear, peek front, peek rear) and a word for pushes. Every
// request gives exactly one result on m_valid/m_ready/m_data: the word read,
// a status (ok, empty, full) and the number of stored words afterwards.
// A taken request is executed: the word store is read into a register and
// the status and count are captured as a pending result, which then moves
// into the output register. The controller takes no new request until the
// pending result has moved to the output register.
// The output register decouples the sides: when the receiver stalls, one
// finished result waits there while the next request is taken and executed;
// s_ready then stays low until the waiting result is taken.
// Reset (aresetn low, synchronous) empties the queue and clears the result
// valid; the store contents are not cleared, since only written slots are read.
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dq_pkg::request_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dq_pkg::result_t        m_data
);

    dq_pkg::dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* src/dq_checker.sv */
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none

module dq_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire dq_pkg::request_t  s_data,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire dq_pkg::result_t   m_data
);

    localparam logic [63:0] EMPTY_WORD = 64'({DATA_WIDTH{1'b1}});
    localparam logic [dq_pkg::FILL_W-1:0] FULL_FILL = dq_pkg::FILL_W'(DEPTH);

    // Reset leaves no result and an open request port
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result valid or request port closed after reset");

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // A taken request closes the port for the store read cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken in back-to-back cycles");

    // A dropped push reports a full store and no word
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == dq_pkg::ST_FULL)
        |-> (m_data.fill_count == FULL_FILL) && (m_data.read_value == '0))
        else $error("full status with wrong count or word");

    // An empty read reports zero words and the all-ones word
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == dq_pkg::ST_EMPTY)
        |-> (m_data.fill_count == '0)
            && (m_data.read_value == EMPTY_WORD[dq_pkg::WORD_W-1:0]))
        else $error("empty status with wrong count or word");

endmodule

bind double_ended_queue_top dq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (.*);

`default_nettype wire

/* tb/sv/double_ended_queue_top_test.sv */
// Self-checking testbench for the double-ended queue: directed and random traffic against a deque predictor.
`timescale 1ns / 1ps

module double_ended_queue_top_test;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT = 200000;

    // One request plus the idle cycles the sender leaves before offering it
    typedef struct packed {
        logic [7:0]       gap_before;
        dq_pkg::request_t req;
    } pending_request_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    dq_pkg::request_t s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    dq_pkg::result_t  m_data;

    pending_request_t pending_requests[$];
    dq_pkg::result_t  expected_results[$];

    // Predicted deque contents
    logic [dq_pkg::WORD_W-1:0] deque_store[QUEUE_DEPTH];
    logic [3:0]                deque_head = '0;
    logic [4:0]                deque_count = '0;

    int   mismatch_count = 0;
    int   results_taken = 0;
    int   cycle_count = 0;
    int   send_gap_count = 0;
    int   stall_left = 0;
    int   long_hold_left = 0;
    int   long_holds_done = 0;
    int   rx_phase_left = 0;
    int   rx_mode = 0;

    double_ended_queue_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Apply one request to the predicted deque and return the result it gives
    function automatic dq_pkg::result_t apply_deque_op(dq_pkg::request_t req);
        dq_pkg::result_t res;
        logic [3:0]      slot;
        logic [4:0]      last;
        res.read_value = '0;
        res.status = dq_pkg::ST_OK;
        case (req.opcode)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
                if (deque_count == QUEUE_DEPTH) begin
                    res.status = dq_pkg::ST_FULL;
                end else if (req.opcode == dq_pkg::OP_PUSH_FRONT) begin
                    deque_head = deque_head - 4'd1;
                    deque_store[deque_head] = req.push_value;
                    deque_count = deque_count + 5'd1;
                end else begin
                    slot = deque_head + deque_count[3:0];
                    deque_store[slot] = req.push_value;
                    deque_count = deque_count + 5'd1;
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR,
            dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_REAR: begin
                if (deque_count == 0) begin
                    res.read_value = '1;
                    res.status = dq_pkg::ST_EMPTY;
                end else begin
                    last = deque_count - 5'd1;
                    if (req.opcode == dq_pkg::OP_POP_FRONT
                        || req.opcode == dq_pkg::OP_PEEK_FRONT) begin
                        slot = deque_head;
                    end else begin
                        slot = deque_head + last[3:0];
                    end
                    res.read_value = deque_store[slot];
                    if (req.opcode == dq_pkg::OP_POP_FRONT) begin
                        deque_head = deque_head + 4'd1;
                        deque_count = last;
                    end else if (req.opcode == dq_pkg::OP_POP_REAR) begin
                        deque_count = last;
                    end
                end
            end
            default: begin
            end
        endcase
        res.fill_count = deque_count;
        return res;
    endfunction

    // Driver: predict each accepted request, then offer the next one after its gap
    always @(posedge aclk) begin
        pending_request_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), apply_deque_op(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (send_gap_count < pending_requests[0].gap_before) begin
                    send_gap_count <= send_gap_count + 1;
                    s_valid <= 1'b0;
                end else begin
                    next_item = pending_requests.pop_front();
                    s_data <= next_item.req;
                    s_valid <= 1'b1;
                    send_gap_count <= 0;
                end
            end
        end
    end

    // Receiver: random stalls by phase, plus two long hold-offs to back up the input
    always @(posedge aclk) begin
        int roll;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
            long_hold_left <= 0;
            rx_phase_left <= 0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_phase_left <= 200;
            end else begin
                rx_phase_left <= rx_phase_left - 1;
            end
            if (long_hold_left > 0) begin
                long_hold_left <= long_hold_left - 1;
                m_ready <= 1'b0;
            end else if (long_holds_done < 2 && results_taken >= 120 + 150 * long_holds_done) begin
                long_hold_left <= 90;
                long_holds_done <= long_holds_done + 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (rx_mode == 1 && $urandom_range(0, 99) < 30) begin
                    stall_left <= $urandom_range(1, 3);
                end else if (rx_mode == 2) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10) begin
                        stall_left <= $urandom_range(1, 3);
                    end else if (roll < 14) begin
                        stall_left <= $urandom_range(10, 40);
                    end else begin
                        stall_left <= 0;
                    end
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        dq_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_taken <= results_taken + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result: read_value %0d status %0d fill_count %0d",
                       m_data.read_value, m_data.status, m_data.fill_count);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           m_data.read_value);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatch_count = mismatch_count + 1;
                end
                if (m_data.fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count,
                           m_data.fill_count);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_request(logic [dq_pkg::OPCODE_W-1:0] op,
                                 logic [dq_pkg::WORD_W-1:0] value, int gap);
        pending_request_t item;
        item.gap_before = gap[7:0];
        item.req.opcode = op;
        item.req.push_value = value;
        pending_requests.insert(pending_requests.size(), item);
    endtask

    function automatic logic [dq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 60) begin
            return 0;
        end else if (mode == 1 || r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Stimulus and end of run
    initial begin
        logic [dq_pkg::OPCODE_W-1:0] reads[4];
        int                          random_count;
        int                          seg_len;
        int                          push_pct;
        int                          gap_mode;
        logic [dq_pkg::OPCODE_W-1:0] op;
        reads = '{dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR,
                  dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_REAR};

        // Reads on an empty queue
        queue_request(dq_pkg::OP_PEEK_FRONT, 32'h1234_5678, 0);
        queue_request(dq_pkg::OP_PEEK_REAR, 32'h0, 0);
        queue_request(dq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF, 0);
        queue_request(dq_pkg::OP_POP_REAR, 32'h0, 0);
        // Fill to capacity from both ends; the first front push wraps the head
        queue_request(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0);
        queue_request(dq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF, 0);
        queue_request(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 0);
        queue_request(dq_pkg::OP_PUSH_REAR, 32'h0000_0000, 0);
        queue_request(dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 0);
        queue_request(dq_pkg::OP_PUSH_REAR, 32'h5555_5555, 0);
        for (int i = 0; i < 10; i++) begin
            queue_request((i % 2) ? dq_pkg::OP_PUSH_REAR : dq_pkg::OP_PUSH_FRONT,
                          $urandom, 0);
        end
        // Pushes to a full queue are dropped
        queue_request(dq_pkg::OP_PUSH_FRONT, 32'h0BAD_0001, 0);
        queue_request(dq_pkg::OP_PUSH_REAR, 32'h0BAD_0002, 0);
        queue_request(dq_pkg::OP_PEEK_FRONT, 32'h0, 0);
        queue_request(dq_pkg::OP_PEEK_REAR, 32'h0, 0);
        queue_request(dq_pkg::OP_POP_FRONT, 32'h0, 0);
        queue_request(dq_pkg::OP_POP_REAR, 32'h0, 0);

        // Random segments that lean toward filling, draining or balance
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 50);
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 50;
            endcase
            gap_mode = $urandom_range(0, 2);
            for (int i = 0; i < seg_len; i++) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_REAR : dq_pkg::OP_PUSH_FRONT;
                end else begin
                    op = reads[$urandom_range(0, 3)];
                end
                queue_request(op, pick_word(), pick_gap(gap_mode));
            end
            random_count += seg_len;
        end

        // Hold reset, then release
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain everything, then leave room for any stray result
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
